// ===== rtl/xte_pkg.sv =====
// ----------------------------------------------------------------------------
// xte_pkg : shared types, character codes and escape helpers
// Holds the expansion record passed from the decoder to the byte emitter,
// the character codes of the escape syntax and the per-byte escape function.
// ----------------------------------------------------------------------------
`default_nettype none

package xte_pkg;

  typedef logic [7:0] char_t;

  // Largest number of output bytes one input byte can cause ("&amp;#&#xHH;").
  localparam int MaxOut  = 12;
  localparam int CntW    = $clog2(MaxOut + 1);
  localparam int EscMax  = 6;
  localparam int EscCntW = $clog2(EscMax + 1);

  // Held-prefix codes.
  localparam logic [1:0] HELD_NONE     = 2'd0;
  localparam logic [1:0] HELD_AMP      = 2'd1;
  localparam logic [1:0] HELD_AMP_HASH = 2'd2;

  // Character codes.
  localparam char_t CH_AMP  = 8'h26;
  localparam char_t CH_LT   = 8'h3C;
  localparam char_t CH_GT   = 8'h3E;
  localparam char_t CH_QUOT = 8'h22;
  localparam char_t CH_APOS = 8'h27;
  localparam char_t CH_HASH = 8'h23;
  localparam char_t CH_X    = 8'h78;
  localparam char_t CH_SEMI = 8'h3B;
  localparam char_t PrintLo = 8'd32;
  localparam char_t PrintHi = 8'd126;

  typedef struct packed {
    char_t [EscMax-1:0] data;
    logic [EscCntW-1:0] len;
  } esc_t;

  // Full output of one accepted input byte, index 0 goes out first.
  typedef struct packed {
    char_t [MaxOut-1:0] data;
    logic [CntW-1:0]    len;
    logic               last;
  } exp_t;

  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

  // Escaped form of a single byte.
  function automatic esc_t esc_byte(input char_t b);
    esc_t e;
    e.data = '0;
    e.len  = EscCntW'(1);
    e.data[0] = b;
    case (b)
      CH_AMP: begin
        e.data[0] = "&"; e.data[1] = "a"; e.data[2] = "m"; e.data[3] = "p";
        e.data[4] = ";"; e.len = EscCntW'(5);
      end
      CH_LT: begin
        e.data[0] = "&"; e.data[1] = "l"; e.data[2] = "t"; e.data[3] = ";";
        e.len = EscCntW'(4);
      end
      CH_GT: begin
        e.data[0] = "&"; e.data[1] = "g"; e.data[2] = "t"; e.data[3] = ";";
        e.len = EscCntW'(4);
      end
      CH_QUOT: begin
        e.data[0] = "&"; e.data[1] = "q"; e.data[2] = "u"; e.data[3] = "o";
        e.data[4] = "t"; e.data[5] = ";"; e.len = EscCntW'(6);
      end
      CH_APOS: begin
        e.data[0] = "&"; e.data[1] = "a"; e.data[2] = "p"; e.data[3] = "o";
        e.data[4] = "s"; e.data[5] = ";"; e.len = EscCntW'(6);
      end
      default: begin
        if (b < PrintLo || b > PrintHi) begin
          e.data[0] = "&"; e.data[1] = "#"; e.data[2] = "x";
          e.data[3] = hex_char(b[7:4]);
          e.data[4] = hex_char(b[3:0]);
          e.data[5] = ";";
          e.len = EscCntW'(6);
        end
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xte_expand.sv =====
// ----------------------------------------------------------------------------
// xte_expand : prefix tracker and byte expansion
// Keeps the held-prefix and raw-run state and turns each accepted byte into
// the complete list of bytes it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_expand
  import xte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  take,
  input  wire char_t in_byte,
  input  wire logic  in_last,
  output exp_t       expansion
);

  logic [1:0] held_r, held_nxt;
  logic       raw_r, raw_nxt;

  // Flushed prefix: "&amp;" then "#".
  char_t [EscMax-1:0] prefix;
  assign prefix = {"#", ";", "p", "m", "a", "&"};

  always_comb begin
    esc_t               esc;
    char_t [EscMax-1:0] tail;
    logic [EscCntW-1:0] tl;
    logic [2:0]         pl;
    logic               fresh;
    logic [CntW-1:0]    off;

    esc      = esc_byte(in_byte);
    held_nxt = HELD_NONE;
    raw_nxt  = 1'b0;
    fresh    = 1'b0;
    pl       = 3'd0;
    tail     = '0;
    tl       = '0;

    if (raw_r) begin
      tail[0] = in_byte;
      tl      = EscCntW'(1);
      raw_nxt = !(in_byte == CH_SEMI || in_last);
    end else begin
      case (held_r)
        HELD_AMP: begin
          if (in_byte == CH_HASH && !in_last) begin
            held_nxt = HELD_AMP_HASH;
          end else begin
            pl    = 3'd5;
            fresh = 1'b1;
          end
        end
        HELD_AMP_HASH: begin
          if (in_byte == CH_X) begin
            tail[0] = "&"; tail[1] = "#"; tail[2] = "x";
            tl      = EscCntW'(3);
            raw_nxt = !in_last;
          end else begin
            pl    = 3'd6;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
    end

    if (fresh) begin
      if (in_byte == CH_AMP && !in_last) begin
        held_nxt = HELD_AMP;
      end else begin
        tail = esc.data;
        tl   = esc.len;
      end
    end

    expansion.data = '0;
    for (int k = 0; k < MaxOut; k++) begin
      off = CntW'(k) - CntW'(pl);
      if (CntW'(k) < CntW'(pl)) begin
        expansion.data[k] = prefix[k[2:0]];
      end else if (off < CntW'(EscMax)) begin
        expansion.data[k] = tail[off[2:0]];
      end
    end
    expansion.len  = CntW'(pl) + CntW'(tl);
    expansion.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= HELD_NONE;
      raw_r  <= 1'b0;
    end else if (take) begin
      held_r <= held_nxt;
      raw_r  <= raw_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xte_emit.sv =====
// ----------------------------------------------------------------------------
// xte_emit : expansion buffer and output byte sequencer
// Holds one expansion and hands its bytes out one beat at a time, taking
// the next expansion in the same cycle as its final beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_emit
  import xte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  take,
  input  wire exp_t  expansion,
  output logic       load_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output char_t      out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  char_t [MaxOut-1:0] buf_r;
  logic [CntW-1:0]    len_r;
  logic [CntW-1:0]    idx_r;
  logic               last_r;
  logic               busy_r;
  logic               at_end;

  assign at_end       = (idx_r == len_r - CntW'(1));
  assign out_valid    = busy_r;
  assign out_byte     = buf_r[idx_r];
  assign out_run_last = at_end;
  assign out_text_end = at_end & last_r;
  assign load_ready   = !busy_r || (out_ready && at_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (take) begin
      busy_r <= (expansion.len != '0);
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_r  <= expansion.data;
      len_r  <= expansion.len;
      last_r <= expansion.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xml_text_escaper.sv =====
// ----------------------------------------------------------------------------
// xml_text_escaper : streaming XML text escaper
// Turns a text string, one byte per beat, into its escaped XML form, one
// byte per beat, leaving "&#x...;" character references untouched.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata               | tlast          | tuser
//  --------+-----------+---------------------+----------------+---------------
//  in_     | slave     | [7:0] in_byte       | in_last        | -
//  out_    | master    | [7:0] out_byte      | text_end       | run_last
//
//  Plain text, whose bytes pass through unchanged, streams at one beat per
//  cycle while the output is not stalled.  A byte that expands into an
//  entity produces up to twelve output bytes, one per beat, because the
//  output port sends one byte per beat; in_tready stays low until the final
//  byte of the expansion leaves.  A '&' or '#' that is held back produces no
//  output beat.  Reset (rst_n low, synchronous) empties the buffer and
//  clears the held prefix and raw-run state.  A stall on the output holds
//  the current byte and back-pressures the input.
//
// The decoder works on the input beat directly: when a beat is accepted
// its whole expansion is computed and written into the emit buffer in the
// same clock edge, while the held-prefix and raw-run state advance.  The
// emit buffer then serves as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_text_escaper
  import xte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  // Output stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // text_end
  output logic            out_tuser   // run_last
);

  exp_t expansion;
  logic take;

  // A valid beat is taken whenever the buffer is empty or is handing out its
  // final byte in this cycle.
  assign take = in_tvalid & in_tready;

  xte_expand u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .expansion (expansion)
  );

  xte_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .expansion    (expansion),
    .load_ready   (in_tready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_run_last (out_tuser),
    .out_text_end (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/xte_checker.sv =====
// ----------------------------------------------------------------------------
// xte_checker : port-level checks for the XML text escaper
// Watches the stream ports over time and flags broken input holding or output sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  // A waiting input beat is held by the sender until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=>
      in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input beat changed while waiting");

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // The end of the string is always the end of an expansion.
  a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("text end flagged on a byte that is not the end of its expansion");

  // An expansion is sent without gaps.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser |=> out_tvalid)
    else $error("gap inside an expansion");

  // No input is taken while an expansion is part way out.
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !in_tready)
    else $error("input accepted in the middle of an expansion");

endmodule

bind xml_text_escaper xte_checker u_xte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== test/xte_stream_checker.sv =====
// ----------------------------------------------------------------------------
// xte_stream_checker : escaped-output predictor and scoreboard
// Watches both streams of the XML text escaper. It works out the escaped
// bytes for every accepted input beat and compares each output beat with
// the oldest one still outstanding.
// ----------------------------------------------------------------------------
module xte_stream_checker
  import xte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] in_byte
  input  wire logic       in_tlast,     // in_last
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,    // [7:0] out_byte
  input  wire logic       out_tlast,    // text_end
  input  wire logic       out_tuser,    // run_last
  output int              escaped_left,
  output int              fail_count
);

  typedef struct packed {
    char_t ch;
    logic  run_last;
    logic  text_end;
  } esc_beat_t;

  esc_beat_t  escaped_q[$];
  esc_beat_t  step_q[$];
  logic [1:0] held = HELD_NONE;
  logic       raw_run = 1'b0;
  int         errs = 0;

  function automatic char_t hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + char_t'(nib);
    end
    return 8'h41 + char_t'(nib) - 8'd10;
  endfunction

  task automatic put_char(input char_t c);
    esc_beat_t b;
    b.ch       = c;
    b.run_last = 1'b0;
    b.text_end = 1'b0;
    step_q = {step_q, b};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(char_t'(s[i]));
    end
  endtask

  task automatic put_escaped(input char_t c);
    case (c)
      CH_AMP:  put_text("&amp;");
      CH_LT:   put_text("&lt;");
      CH_GT:   put_text("&gt;");
      CH_QUOT: put_text("&quot;");
      CH_APOS: put_text("&apos;");
      default: begin
        if (c < PrintLo || c > PrintHi) begin
          put_text("&#x");
          put_char(hex_digit(c[7:4]));
          put_char(hex_digit(c[3:0]));
          put_char(CH_SEMI);
        end else begin
          put_char(c);
        end
      end
    endcase
  endtask

  // A byte seen with nothing held: an ampersand mid-string is held back.
  task automatic take_fresh(input char_t c, input logic last);
    if (c == CH_AMP && !last) begin
      held = HELD_AMP;
    end else begin
      put_escaped(c);
    end
  endtask

  task automatic predict_escape(input char_t c, input logic last);
    logic [1:0] was_held;
    esc_beat_t  tail;
    step_q.delete();
    was_held = held;
    held     = HELD_NONE;
    if (raw_run) begin
      put_char(c);
      if (c == CH_SEMI || last) begin
        raw_run = 1'b0;
      end
    end else begin
      case (was_held)
        HELD_AMP: begin
          if (c == CH_HASH && !last) begin
            held = HELD_AMP_HASH;
          end else begin
            put_text("&amp;");
            take_fresh(c, last);
          end
        end
        HELD_AMP_HASH: begin
          if (c == CH_X) begin
            put_text("&#x");
            if (!last) begin
              raw_run = 1'b1;
            end
          end else begin
            put_text("&amp;");
            put_char(CH_HASH);
            take_fresh(c, last);
          end
        end
        default: take_fresh(c, last);
      endcase
    end
    if (step_q.size() > 0) begin
      tail          = step_q.pop_back();
      tail.run_last = 1'b1;
      tail.text_end = last;
      step_q = {step_q, tail};
    end
    escaped_q = {escaped_q, step_q};
  endtask

  // Outputs are compared before the input of the same edge is predicted, so a
  // beat can only ever match bytes owed by earlier input beats.
  always @(posedge clk) begin
    esc_beat_t want;
    if (!rst_n) begin
      held    = HELD_NONE;
      raw_run = 1'b0;
      escaped_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (escaped_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected output beat: byte %h run_last %b text_end %b",
                     out_tdata, out_tuser, out_tlast);
          end
        end else begin
          want = escaped_q.pop_front();
          if (want.ch !== out_tdata || want.run_last !== out_tuser ||
              want.text_end !== out_tlast) begin
            errs++;
            if (errs <= 10) begin
              $display("output mismatch: expected byte %h run_last %b text_end %b, got %h %b %b",
                       want.ch, want.run_last, want.text_end,
                       out_tdata, out_tuser, out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_escape(in_tdata, in_tlast);
      end
    end
    escaped_left <= escaped_q.size();
    fail_count   <= errs;
  end

endmodule

// ===== test/xml_text_escaper_tb.sv =====
// ----------------------------------------------------------------------------
// xml_text_escaper_tb : stimulus and verdict for the XML text escaper
// Sends directed strings covering every entity, the printable limits and all
// the held-prefix and raw-reference corner cases, then random strings built
// mostly from well-formed fragments, with random idling on both streams. The
// checker module beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module xml_text_escaper_tb;
  import xte_pkg::*;

  // Cycles with no beat on either stream before the run is abandoned. One
  // input byte costs at most twelve output beats, each of which may wait out
  // a random stall of the sink, so a few thousand is ample.
  localparam int StallLimit  = 4000;
  // Cycles allowed after the last expected byte, for anything stray to show.
  localparam int TailCycles  = 24;
  localparam int RandomItems = 75;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int escaped_left;
  int fail_count;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int beats_taken  = 0;
  bit src_eager    = 1'b0;
  bit sink_eager   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xml_text_escaper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // in_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tlast  (out_tlast),   // text_end
    .out_tuser  (out_tuser)    // run_last
  );

  xte_stream_checker scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .escaped_left (escaped_left),
    .fail_count   (fail_count)
  );

  // Watchdog: any beat on either stream, or reset, restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("xml_text_escaper_tb: done, errors");
      $finish;
    end
  end

  // Output side. Each beat is preceded by a random stall; every sixteen beats
  // the sink may switch into a stretch where it never stalls at all.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats_taken % 16 == 0) begin
        sink_eager = ($urandom_range(0, 3) == 0);
      end
      gap = sink_eager ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats_taken++;
    end
  end

  // Presents one input byte after a random gap and returns at the edge where
  // it is taken. With no gap, valid simply stays high into the next beat, so
  // it is never dropped and raised again within one step.
  task automatic send_beat(input char_t c, input logic last);
    int gap;
    if (items_sent % 16 == 0) begin
      src_eager = ($urandom_range(0, 3) == 0);
    end
    gap = src_eager ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Sends the characters of s; the last one closes the string if asked to.
  task automatic send_text(input string s, input bit closes);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(char_t'(s[i]), closes && (i == s.len() - 1));
    end
  endtask

  // One random string, built mostly from fragments that reach the held-prefix
  // and raw-reference states, with plain text and arbitrary bytes mixed in.
  task automatic send_random_string();
    char_t text_q[$];
    int    tokens;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2: text_q = {text_q, char_t'($urandom_range(32, 126))};
        3: text_q = {text_q, char_t'($urandom_range(0, 255))};
        4: begin
          case ($urandom_range(0, 4))
            0: text_q = {text_q, CH_AMP};
            1: text_q = {text_q, CH_LT};
            2: text_q = {text_q, CH_GT};
            3: text_q = {text_q, CH_QUOT};
            default: text_q = {text_q, CH_APOS};
          endcase
        end
        5, 6, 7: begin
          // A character reference, sometimes left open so the string end
          // has to close the raw run.
          text_q = {text_q, CH_AMP, CH_HASH, CH_X};
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              text_q = {text_q, char_t'($urandom_range(0, 255))};
            end else begin
              text_q = {text_q, char_t'($urandom_range(32, 126))};
            end
          end
          if ($urandom_range(0, 4) != 0) begin
            text_q = {text_q, CH_SEMI};
          end
        end
        8: begin
          text_q = {text_q, CH_AMP, char_t'($urandom_range(0, 255))};
        end
        default: begin
          text_q = {text_q, CH_AMP, CH_HASH, char_t'($urandom_range(0, 255))};
        end
      endcase
    end
    foreach (text_q[i]) begin
      send_beat(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Holds the input off until every byte owed has left the block. The count
  // from the checker is registered, so it is first read after the next edge.
  task automatic drain_output();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (escaped_left != 0);
  endtask

  initial begin
    int  random_start;
    bit  paused;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every entity but the ampersand, the printable limits, then the hex-reference
    // range at both ends and in the middle; the top byte closes the string.
    send_text("<>\"' ~", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hFF, 1'b1);
    // A reference closed by its semicolon, then an ampersand held back and
    // flushed by the final byte.
    send_text("&#x4F;&z", 1'b1);
    // Held ampersand broken by a second ampersand, then a held "&#" broken
    // by a byte that is not an x and also ends the string.
    send_text("&&#y", 1'b1);
    // The string ends right on the x of a reference.
    send_text("&#x", 1'b1);
    // The string ends inside an open raw run.
    send_text("&#x1", 1'b1);

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      send_random_string();
      if (!paused && items_sent - random_start >= RandomItems / 2) begin
        drain_output();
        paused = 1'b1;
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (escaped_left != 0);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0 && escaped_left == 0) begin
      $display("xml_text_escaper_tb: done, clean");
    end else begin
      $display("xml_text_escaper_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xte_pkg.sv
rtl/xte_expand.sv
rtl/xte_emit.sv
rtl/xml_text_escaper.sv
rtl/xte_checker.sv
test/xte_stream_checker.sv
test/xml_text_escaper_tb.sv
